[design/websocket_frame_deframer_unit_defines.svh]
// Assertion macros for the frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define WSFD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wsfd: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define WSFD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wsfd: next-cycle check failed");

`endif

[design/wsfd_pkg.sv]
`timescale 1ns / 1ps

package wsfd_pkg;

   // frame status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CLOSE   = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_IGNORED = 2'd3
   } status_type;

   // result kinds
   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   // opcodes that the block handles
   localparam logic [3:0] OPC_TEXT   = 4'h1;
   localparam logic [3:0] OPC_BINARY = 4'h2;
   localparam logic [3:0] OPC_CLOSE  = 4'h8;

   // 7-bit length codes that select a longer length field
   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // packet lengths at or below which a frame is rejected as invalid or ignored
   localparam logic [15:0] MIN_PACKET_LEN = 16'd1;
   localparam logic [15:0] MIN_DATA_LEN   = 16'd6;

   // result queue, depth a power of two so the pointers wrap on their own
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      status_type  frame_status;
      logic [3:0]  frame_opcode;
      logic        run_last;
   } result_type;

endpackage

[design/websocket_frame_deframer_unit.sv]
`timescale 1ns / 1ps
// Results: each accepted input beat writes its results into a registered result queue.
// Throughput: one input beat per cycle; a beat that ends a frame with a payload
// byte makes two results, and input stalls only while fewer than two of the
// four result queue entries are free, which happens only when the result side backs up.
// Reset: synchronous, active high; clears all frame state and empties the queue.

`include "websocket_frame_deframer_unit_defines.svh"

module websocket_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_packet_length,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_index,
   output logic [1:0]  rsp_frame_status,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_run_last
);

   localparam logic [16:0] POS_MAX = 17'h1FFFF;

   // frame state
   logic [16:0]          pos_ff, pos_in;
   logic [3:0]           opcode_ff, opcode_in;
   logic [15:0]          length_ff, length_in;
   logic                 ext_ff, ext_in;
   logic [31:0]          key_ff, key_in;
   logic [15:0]          pcount_ff, pcount_in;
   wsfd_pkg::status_type verdict_ff, verdict_in;

   // result queue
   wsfd_pkg::result_type                 queue_ff [wsfd_pkg::QUEUE_DEPTH];
   logic [wsfd_pkg::QPTR_W-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [wsfd_pkg::QCNT_W-1:0]          count_ff, count_in;

   logic                 in_fire, out_fire;
   logic [6:0]           len7;
   logic [16:0]          key_start, pay_start;
   logic                 in_key, emit_pay;
   logic [7:0]           key_byte;
   wsfd_pkg::result_type pay_res, stat_res, first_res;
   logic [1:0]           push_cnt;
   wsfd_pkg::result_type head;

   assign in_fire  = req_valid && req_ready;
   assign out_fire = rsp_valid && rsp_ready;
   assign len7     = req_data_byte[6:0];

   // decode header and unmask payload for the beat at the input
   always_comb begin
      opcode_in  = opcode_ff;
      verdict_in = verdict_ff;
      length_in  = length_ff;
      ext_in     = ext_ff;
      key_in     = key_ff;
      pcount_in  = pcount_ff;
      if (pos_ff == 17'd0) begin
         opcode_in = req_data_byte[3:0];
         if (req_packet_length <= wsfd_pkg::MIN_PACKET_LEN) begin
            verdict_in = wsfd_pkg::STATUS_INVALID;
         end else if (!req_data_byte[7]) begin
            verdict_in = wsfd_pkg::STATUS_IGNORED;
         end else if (opcode_in == wsfd_pkg::OPC_CLOSE) begin
            verdict_in = wsfd_pkg::STATUS_CLOSE;
         end else if (opcode_in != wsfd_pkg::OPC_TEXT &&
                      opcode_in != wsfd_pkg::OPC_BINARY) begin
            verdict_in = wsfd_pkg::STATUS_IGNORED;
         end else if (req_packet_length <= wsfd_pkg::MIN_DATA_LEN) begin
            verdict_in = wsfd_pkg::STATUS_IGNORED;
         end else begin
            verdict_in = wsfd_pkg::STATUS_OK;
         end
      end else if (verdict_ff == wsfd_pkg::STATUS_OK) begin
         if (pos_ff == 17'd1) begin
            if (len7 == wsfd_pkg::LEN_CODE_64) begin
               verdict_in = wsfd_pkg::STATUS_IGNORED;
            end else if (len7 == wsfd_pkg::LEN_CODE_16) begin
               ext_in    = 1'b1;
               length_in = 16'd0;
            end else begin
               length_in = {9'd0, len7};
               if (length_in > req_packet_length) begin
                  verdict_in = wsfd_pkg::STATUS_INVALID;
               end
            end
         end else if (ext_ff && pos_ff == 17'd2) begin
            length_in = {req_data_byte, 8'h00};
         end else if (ext_ff && pos_ff == 17'd3) begin
            length_in = {length_ff[15:8], req_data_byte};
            if (length_in > req_packet_length) begin
               verdict_in = wsfd_pkg::STATUS_INVALID;
            end
         end
      end

      // key bytes follow the length field, payload follows the key
      key_start = ext_in ? 17'd4 : 17'd2;
      pay_start = ext_in ? 17'd8 : 17'd6;
      in_key    = (verdict_in == wsfd_pkg::STATUS_OK) &&
                  (pos_ff >= key_start) && (pos_ff < pay_start);
      emit_pay  = (verdict_in == wsfd_pkg::STATUS_OK) && !in_key &&
                  (pos_ff >= pay_start) && (pcount_ff < length_in);

      case (pcount_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase

      if (in_key) begin
         key_in = {key_ff[23:0], req_data_byte};
      end
      if (emit_pay) begin
         pcount_in = pcount_ff + 16'd1;
      end

      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 17'd1;

      // build the results of this beat
      pay_res.kind          = wsfd_pkg::KIND_PAYLOAD;
      pay_res.payload_byte  = req_data_byte ^ key_byte;
      pay_res.payload_index = pcount_ff;
      pay_res.frame_status  = wsfd_pkg::STATUS_OK;
      pay_res.frame_opcode  = 4'd0;
      pay_res.run_last      = !req_last_byte;

      stat_res.kind          = wsfd_pkg::KIND_STATUS;
      stat_res.payload_byte  = 8'd0;
      stat_res.payload_index = pcount_in;
      stat_res.frame_status  = (req_packet_length <= wsfd_pkg::MIN_PACKET_LEN) ?
                               wsfd_pkg::STATUS_INVALID : verdict_in;
      stat_res.frame_opcode  = opcode_in;
      stat_res.run_last      = 1'b1;

      first_res = emit_pay ? pay_res : stat_res;
      push_cnt  = {1'b0, emit_pay} + {1'b0, req_last_byte};

      // the last beat returns the frame state to its reset value
      if (req_last_byte) begin
         pos_in     = 17'd0;
         opcode_in  = 4'd0;
         length_in  = 16'd0;
         ext_in     = 1'b0;
         key_in     = 32'd0;
         pcount_in  = 16'd0;
         verdict_in = wsfd_pkg::STATUS_OK;
      end
   end

   // advance frame state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 17'd0;
         opcode_ff  <= 4'd0;
         length_ff  <= 16'd0;
         ext_ff     <= 1'b0;
         key_ff     <= 32'd0;
         pcount_ff  <= 16'd0;
         verdict_ff <= wsfd_pkg::STATUS_OK;
      end else if (in_fire) begin
         pos_ff     <= pos_in;
         opcode_ff  <= opcode_in;
         length_ff  <= length_in;
         ext_ff     <= ext_in;
         key_ff     <= key_in;
         pcount_ff  <= pcount_in;
         verdict_ff <= verdict_in;
      end
   end

   // hold room for two results before taking a beat
   assign req_ready = (count_ff <= wsfd_pkg::QCNT_W'(wsfd_pkg::QUEUE_DEPTH - 2));
   assign count_in  = count_ff
                      + (in_fire ? wsfd_pkg::QCNT_W'(push_cnt) : '0)
                      - wsfd_pkg::QCNT_W'(out_fire);

   // queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (in_fire) begin
            wr_ptr_ff <= wr_ptr_ff + wsfd_pkg::QPTR_W'(push_cnt);
         end
         if (out_fire) begin
            rd_ptr_ff <= rd_ptr_ff + wsfd_pkg::QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // write one or two results into the queue
   always_ff @(posedge clock) begin
      if (in_fire && push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_res;
      end
      if (in_fire && push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + wsfd_pkg::QPTR_W'(1)] <= stat_res;
      end
   end

   // drive the head of the queue
   assign head              = queue_ff[rd_ptr_ff];
   assign rsp_valid         = (count_ff != '0);
   assign rsp_kind          = head.kind;
   assign rsp_payload_byte  = head.payload_byte;
   assign rsp_payload_index = head.payload_index;
   assign rsp_frame_status  = head.frame_status;
   assign rsp_frame_opcode  = head.frame_opcode;
   assign rsp_run_last      = head.run_last;

   `WSFD_ASSERT_IMP(a_queue_bound, 1'b1,
                    count_ff <= wsfd_pkg::QCNT_W'(wsfd_pkg::QUEUE_DEPTH))
   `WSFD_ASSERT_NXT(a_frame_restart, in_fire && req_last_byte,
                    pos_ff == 17'd0 && verdict_ff == wsfd_pkg::STATUS_OK && pcount_ff == 16'd0)
   `WSFD_ASSERT_IMP(a_payload_clean, rsp_valid && rsp_kind == wsfd_pkg::KIND_PAYLOAD,
                    rsp_frame_status == wsfd_pkg::STATUS_OK && rsp_frame_opcode == 4'd0)
   `WSFD_ASSERT_NXT(a_push_shows, in_fire && push_cnt != 2'd0, rsp_valid)

endmodule
